/* hw/rtl/idl_pkg.sv */
// ----------------------------------------------------------------------------
// idl_pkg
// Types and constants shared by the indent/dedent layout block.
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam int COL_W = 16;
    localparam int TAG_W = 16;

    localparam logic [COL_W-1:0] BASE_COLUMN = 16'd1;

    localparam logic [2:0] KIND_NEWLINE = 3'd0;
    localparam logic [2:0] KIND_OPEN    = 3'd1;
    localparam logic [2:0] KIND_CLOSE   = 3'd2;
    localparam logic [2:0] KIND_OTHER   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [1:0] OUT_TOKEN  = 2'd0;
    localparam logic [1:0] OUT_INDENT = 2'd1;
    localparam logic [1:0] OUT_DEDENT = 2'd2;
    localparam logic [1:0] OUT_EOF    = 2'd3;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_INCONSISTENT = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW     = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [COL_W-1:0] column;
        logic [TAG_W-1:0] token_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [TAG_W-1:0] out_tag;
        logic [COL_W-1:0] out_column;
        logic [1:0]       status;
        logic             last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_LAYOUT = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [COL_W-1:0] col;
        logic [TAG_W-1:0] tag;
    } t_cmd;

endpackage

/* hw/rtl/idl_front.sv */
// ----------------------------------------------------------------------------
// idl_front
// Accepts input transactions, tracks bracket depth and line start, and turns
// every item but a newline inside brackets into a stack engine command.
// ----------------------------------------------------------------------------
module idl_front #(
    parameter int BRACKET_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  idl_pkg::t_in_item i_in_data,
    input  logic              i_full,
    output logic              o_wr,
    output idl_pkg::t_cmd     o_cmd
);
    import idl_pkg::*;

    logic [BRACKET_BITS-1:0] r_bracket, n_bracket;
    logic                    r_line_start, n_line_start;
    logic                    w_keep;
    logic                    w_accept;
    t_op                     w_op;

    assign w_accept   = i_in_valid && !i_full;
    assign o_in_stall = i_full;

    always_comb begin
        n_bracket    = r_bracket;
        n_line_start = r_line_start;
        w_keep       = 1'b0;
        w_op         = OP_PASS;
        case (i_in_data.kind)
            KIND_NEWLINE: begin
                if (r_bracket == '0) begin
                    w_keep       = 1'b1;
                    n_line_start = 1'b1;
                end
            end
            KIND_OPEN, KIND_CLOSE, KIND_OTHER: begin
                if (i_in_data.kind == KIND_OPEN) begin
                    if (r_bracket != {BRACKET_BITS{1'b1}}) begin
                        n_bracket = r_bracket + 1'b1;
                    end
                end else if (i_in_data.kind == KIND_CLOSE) begin
                    if (r_bracket != '0) begin
                        n_bracket = r_bracket - 1'b1;
                    end
                end
                w_keep       = 1'b1;
                w_op         = r_line_start ? OP_LAYOUT : OP_PASS;
                n_line_start = 1'b0;
            end
            KIND_END: begin
                w_keep       = 1'b1;
                w_op         = OP_FLUSH;
                n_bracket    = '0;
                n_line_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_wr      = w_accept && w_keep;
    assign o_cmd.op  = w_op;
    assign o_cmd.col = i_in_data.column;
    assign o_cmd.tag = i_in_data.token_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bracket    <= '0;
            r_line_start <= 1'b1;
        end else if (w_accept) begin
            r_bracket    <= n_bracket;
            r_line_start <= n_line_start;
        end
    end

endmodule

/* hw/rtl/idl_queue.sv */
// ----------------------------------------------------------------------------
// idl_queue
// Two-entry command queue between the front end and the stack engine.
// ----------------------------------------------------------------------------
module idl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  idl_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output idl_pkg::t_cmd o_cmd,
    input  logic          i_rd
);
    import idl_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* hw/rtl/idl_back.sv */
// ----------------------------------------------------------------------------
// idl_back
// Stack engine: compares columns with the indent stack, pushes and pops one
// entry per cycle unless stalled, and drives the registered result channel.
// ----------------------------------------------------------------------------
module idl_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  idl_pkg::t_cmd      i_cmd,
    output logic               o_rd,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output idl_pkg::t_out_item o_out_data
);
    import idl_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DEDENT = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_TOKEN  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [COL_W-1:0] r_top, n_top;
    logic [COL_W-1:0] r_base, n_base;
    logic [1:0]       r_status, n_status;
    logic [COL_W-1:0] r_rd;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [COL_W-1:0] r_mem [STACK_DEPTH];

    t_out_item        w_item;
    logic             w_emit;
    logic             w_push;
    logic             w_can_emit;
    logic [COL_W-1:0] w_below;
    logic [COL_W-1:0] w_top_cur;
    logic [CW-1:0]    w_rd_idx;
    logic             w_has_room;

    assign w_can_emit = !r_out_valid || !i_out_stall;
    assign w_below    = (r_count == CW'(2)) ? r_base : r_rd;
    assign w_top_cur  = (r_count != '0) ? r_top : '0;
    assign w_has_room = (r_count < CW'(STACK_DEPTH));

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_top             = r_top;
        n_base            = r_base;
        n_status          = r_status;
        w_emit            = 1'b0;
        w_push            = 1'b0;
        o_rd              = 1'b0;
        w_item.out_kind   = OUT_TOKEN;
        w_item.out_tag    = i_cmd.tag;
        w_item.out_column = i_cmd.col;
        w_item.status     = STATUS_OK;
        w_item.last       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && w_can_emit) begin
                    w_emit = 1'b1;
                    case (i_cmd.op)
                        OP_PASS: begin
                            w_item.last = 1'b1;
                            o_rd        = 1'b1;
                        end
                        OP_FLUSH: begin
                            if (r_count > CW'(1)) begin
                                w_item.out_kind = OUT_DEDENT;
                                n_count         = r_count - 1'b1;
                                n_top           = w_below;
                                n_state         = ST_FLUSH;
                            end else begin
                                w_item.out_kind = OUT_EOF;
                                w_item.last     = 1'b1;
                                n_count         = CW'(1);
                                n_top           = BASE_COLUMN;
                                n_base          = BASE_COLUMN;
                                o_rd            = 1'b1;
                            end
                        end
                        OP_LAYOUT: begin
                            if (i_cmd.col > w_top_cur) begin
                                w_item.out_kind = OUT_INDENT;
                                if (w_has_room) begin
                                    w_push   = 1'b1;
                                    n_status = STATUS_OK;
                                end else begin
                                    n_status = STATUS_OVERFLOW;
                                end
                                n_state = ST_TOKEN;
                            end else if (i_cmd.col == w_top_cur) begin
                                w_item.last = 1'b1;
                                o_rd        = 1'b1;
                            end else begin
                                w_item.out_kind = OUT_DEDENT;
                                n_count         = r_count - 1'b1;
                                n_top           = w_below;
                                n_state         = ST_DEDENT;
                            end
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_DEDENT: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    if (r_count != '0 && r_top > i_cmd.col) begin
                        w_item.out_kind = OUT_DEDENT;
                        n_count         = r_count - 1'b1;
                        n_top           = w_below;
                    end else begin
                        if (r_count == '0 || r_top != i_cmd.col) begin
                            w_item.status = STATUS_INCONSISTENT;
                            w_push        = w_has_room;
                        end
                        w_item.last = 1'b1;
                        o_rd        = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    if (r_count > CW'(1)) begin
                        w_item.out_kind = OUT_DEDENT;
                        n_count         = r_count - 1'b1;
                        n_top           = w_below;
                    end else begin
                        w_item.out_kind = OUT_EOF;
                        w_item.last     = 1'b1;
                        n_count         = CW'(1);
                        n_top           = BASE_COLUMN;
                        n_base          = BASE_COLUMN;
                        o_rd            = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end
            end
            ST_TOKEN: begin
                if (w_can_emit) begin
                    w_emit        = 1'b1;
                    w_item.status = r_status;
                    w_item.last   = 1'b1;
                    o_rd          = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_push) begin
            n_top   = i_cmd.col;
            n_count = r_count + 1'b1;
            if (r_count == '0) begin
                n_base = i_cmd.col;
            end
        end
    end

    assign w_rd_idx = n_count - CW'(2);

    always_ff @(posedge i_clk) begin
        if (w_push && r_count != '0) begin
            r_mem[r_count[AW-1:0]] <= i_cmd.col;
        end
        r_rd <= r_mem[w_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= CW'(1);
            r_top       <= BASE_COLUMN;
            r_base      <= BASE_COLUMN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            r_base  <= n_base;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_emit) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/indent_dedent_layout_unit.sv */
// ----------------------------------------------------------------------------
// indent_dedent_layout_unit
// Offside-rule layout: inserts Indent, Dedent and EndOfFile transactions into
// a classified token stream.
// ----------------------------------------------------------------------------
// A front end takes one token transaction per cycle while the queue has room,
// tracks bracket depth and line start, and queues a command in a two-entry
// queue; the stack engine emits one result per cycle, unless the output
// stalls, into a registered output. A passed token gives one result, a deeper
// line's first token gives Indent and the token, a line closing N levels
// gives N Dedents and the token, and an end item gives a Dedent per open
// level and EndOfFile. The indent stack pops entries at that rate through its
// single registered memory read port. No clearing pass is needed after reset.
module indent_dedent_layout_unit #(
    parameter int STACK_DEPTH  = 32,
    parameter int BRACKET_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  idl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output idl_pkg::t_out_item o_out_data
);
    import idl_pkg::*;

    logic w_wr;
    logic w_full;
    logic w_q_valid;
    logic w_q_rd;
    t_cmd w_wr_cmd;
    t_cmd w_head_cmd;

    idl_front #(
        .BRACKET_BITS (BRACKET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_wr       (w_wr),
        .o_cmd      (w_wr_cmd)
    );

    idl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_cmd   (w_wr_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd),
        .i_rd    (w_q_rd)
    );

    idl_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_cmd       (w_head_cmd),
        .o_rd        (w_q_rd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
